// ===== hdl/rbf_pkg.sv =====
package rbf_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [12:0] WIDTH_RESET  = 13'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;
    localparam int          MIN_SIDE     = 3;

    localparam int KERNEL_SIZE = 3;
    localparam int WIN_TAPS    = KERNEL_SIZE * KERNEL_SIZE;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [23:0] rbf_pixel_t;              // {red, green, blue}
    typedef rbf_pixel_t [WIN_TAPS-1:0] rbf_window_t;
    typedef logic [4:0] rbf_term_t;

    // Control carried alongside an item through the pipeline
    typedef struct packed {
        logic emit;
        logic frame_end;
    } rbf_tag_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } rbf_result_t;

    // Rounded v/9 as (v + 4) / 9, by reciprocal: floor(x * 57 / 512) is exact for x < 260
    function automatic rbf_term_t div9_round(input logic [7:0] v);
        logic [8:0]  x;
        logic [14:0] p;
        begin
            x = {1'b0, v} + 9'd4;
            p = 15'(x) * 15'd57;
            return p[13:9];
        end
    endfunction

endpackage

// ===== hdl/rgb_box_filter_3x3.sv =====
// Channel   Dir   Handshake          Payload
// s_        in    s_valid/s_ready    s_red_in, s_green_in, s_blue_in (8 bits each)
// m_        out   m_valid/m_ready    m_red_out, m_green_out, m_blue_out, m_frame_end
// cfg_      in    cfg_wr_en          cfg_index (2 bits), cfg_wdata (16 bits)
//
// One pixel per clock while s_ready is high; a result passes the line memory read at
// the accepting edge, then the window shift, the rounded-ninth register and the queue
// write before it reaches m_valid.
// Reset: 640 x 480 frame, position at zero, window cleared; the line memory is
// not cleared and needs no clearing pass.
// Stalls: results wait in an 8-entry queue; s_ready drops while queued plus
// in-flight results would fill it, so nothing is lost under back-pressure.
module rgb_box_filter_3x3 #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red_out,
    output logic [7:0]  m_green_out,
    output logic [7:0]  m_blue_out,
    output logic        m_frame_end,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);

    // Configuration
    logic [12:0] width_cfg_reg;
    logic [15:0] height_cfg_reg;
    logic        cfg_hit;

    // Position of the next pixel
    logic [CW-1:0] col_reg, col_next;
    logic [15:0]   row_reg, row_next;

    logic [31:0] w_eff, h_eff;
    logic [CW-1:0] col_cur;
    logic [15:0]   row_cur;
    logic          last_col, last_row;
    logic          accept;
    rbf_pkg::rbf_tag_t in_tag;

    // Pipeline
    logic                 s1_valid_reg;
    rbf_pkg::rbf_tag_t    s1_tag_reg, s2_tag_reg, s3_tag_reg;
    rbf_pkg::rbf_pixel_t  s1_pix_reg;
    logic [CW-1:0]        s1_addr_reg;
    logic [47:0]          line_rd;
    rbf_pkg::rbf_window_t win;
    logic [7:0]           red_sum, green_sum, blue_sum;
    logic [2:0]           in_flight;
    logic [rbf_pkg::FIFO_AW:0] q_count;
    rbf_pkg::rbf_result_t res, q_head;

    // Clamp the configured sizes to what the hardware supports
    always_comb begin
        w_eff = 32'(width_cfg_reg);
        if (w_eff < 32'(rbf_pkg::MIN_SIDE)) begin
            w_eff = 32'(rbf_pkg::MIN_SIDE);
        end else if (w_eff > 32'(MAX_WIDTH)) begin
            w_eff = 32'(MAX_WIDTH);
        end
        h_eff = 32'(height_cfg_reg);
        if (h_eff < 32'(rbf_pkg::MIN_SIDE)) begin
            h_eff = 32'(rbf_pkg::MIN_SIDE);
        end
    end

    // Raster position and frame wrap
    always_comb begin
        col_cur  = (32'(col_reg) >= w_eff) ? '0 : col_reg;
        row_cur  = (32'(row_reg) >= h_eff) ? '0 : row_reg;
        last_col = (32'(col_cur) == w_eff - 32'd1);
        last_row = (32'(row_cur) == h_eff - 32'd1);
        in_tag.emit      = (row_cur >= 16'd2) && (col_cur >= CW'(2));
        in_tag.frame_end = last_col && last_row;
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? 16'd0 : row_cur + 16'd1;
            end else begin
                col_next = col_cur + 1'b1;
                row_next = row_cur;
            end
        end
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end
    end

    assign cfg_hit = cfg_wr_en && (cfg_index == rbf_pkg::REG_IMAGE_WIDTH ||
                                   cfg_index == rbf_pkg::REG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= rbf_pkg::WIDTH_RESET;
            height_cfg_reg <= rbf_pkg::HEIGHT_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
        end else begin
            if (cfg_wr_en && cfg_index == rbf_pkg::REG_IMAGE_WIDTH) begin
                width_cfg_reg <= cfg_wdata[12:0];
            end
            if (cfg_wr_en && cfg_index == rbf_pkg::REG_IMAGE_HEIGHT) begin
                height_cfg_reg <= cfg_wdata;
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Count results still on their way to the queue; hold off input before it fills
    assign in_flight = 3'(s1_tag_reg.emit && s1_valid_reg) + 3'(s2_tag_reg.emit)
                     + 3'(s3_tag_reg.emit);
    assign s_ready   = (32'(q_count) + 32'(in_flight)) < 32'(rbf_pkg::FIFO_DEPTH);
    assign accept    = s_valid && s_ready;

    // Stage 1: line memory read in flight, pixel held for the write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_tag_reg   <= '0;
            s2_tag_reg   <= '0;
            s3_tag_reg   <= '0;
        end else begin
            s1_valid_reg <= accept;
            s1_tag_reg   <= accept ? in_tag : '0;
            s2_tag_reg   <= s1_valid_reg ? s1_tag_reg : '0;
            s3_tag_reg   <= s2_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= {s_red_in, s_green_in, s_blue_in};
            s1_addr_reg <= col_cur;
        end
    end

    // Write back: the new pixel becomes the row above, the old row above moves down
    rbf_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (line_rd),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data ({s1_pix_reg, line_rd[47:24]})
    );

    // Stage 2: advance the window with the new column
    rbf_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (s1_valid_reg),
        .top_px   (line_rd[23:0]),
        .mid_px   (line_rd[47:24]),
        .bot_px   (s1_pix_reg),
        .win      (win)
    );

    // Stage 3: rounded ninths registered, summed on the way into the queue
    rbf_mean u_mean (
        .aclk      (aclk),
        .load      (s2_tag_reg.emit),
        .win       (win),
        .red_sum   (red_sum),
        .green_sum (green_sum),
        .blue_sum  (blue_sum)
    );

    assign res.red       = red_sum;
    assign res.green     = green_sum;
    assign res.blue      = blue_sum;
    assign res.frame_end = s3_tag_reg.frame_end;

    rbf_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s3_tag_reg.emit),
        .push_data (res),
        .pop       (m_ready),
        .head      (q_head),
        .not_empty (m_valid),
        .count     (q_count)
    );

    assign m_red_out   = q_head.red;
    assign m_green_out = q_head.green;
    assign m_blue_out  = q_head.blue;
    assign m_frame_end = q_head.frame_end;

endmodule

// ===== hdl/rbf_line_mem.sv =====
module rbf_line_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [47:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [47:0]   wr_data
);

    // Each entry holds {row above, row two above} for one column
    logic [47:0] mem [DEPTH];
    logic [47:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/rbf_window.sv =====
module rbf_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  rbf_pkg::rbf_pixel_t top_px,
    input  rbf_pkg::rbf_pixel_t mid_px,
    input  rbf_pkg::rbf_pixel_t bot_px,
    output rbf_pkg::rbf_window_t win
);

    rbf_pkg::rbf_window_t win_reg;
    rbf_pkg::rbf_window_t win_next;

    // Shift left, newest column enters on the right
    always_comb begin
        win_next = win_reg;
        if (shift_en) begin
            for (int r = 0; r < rbf_pkg::KERNEL_SIZE; r++) begin
                win_next[r*3 + 0] = win_reg[r*3 + 1];
                win_next[r*3 + 1] = win_reg[r*3 + 2];
            end
            win_next[2] = top_px;
            win_next[5] = mid_px;
            win_next[8] = bot_px;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else begin
            win_reg <= win_next;
        end
    end

    assign win = win_reg;

endmodule

// ===== hdl/rbf_mean.sv =====
module rbf_mean (
    input  logic                 aclk,
    input  logic                 load,
    input  rbf_pkg::rbf_window_t win,
    output logic [7:0]           red_sum,
    output logic [7:0]           green_sum,
    output logic [7:0]           blue_sum
);

    rbf_pkg::rbf_term_t red_term_reg   [rbf_pkg::WIN_TAPS];
    rbf_pkg::rbf_term_t green_term_reg [rbf_pkg::WIN_TAPS];
    rbf_pkg::rbf_term_t blue_term_reg  [rbf_pkg::WIN_TAPS];

    // Register the rounded ninths, then add them up in the next cycle
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int k = 0; k < rbf_pkg::WIN_TAPS; k++) begin
                red_term_reg[k]   <= rbf_pkg::div9_round(win[k][23:16]);
                green_term_reg[k] <= rbf_pkg::div9_round(win[k][15:8]);
                blue_term_reg[k]  <= rbf_pkg::div9_round(win[k][7:0]);
            end
        end
    end

    // Nine terms of at most 28 each: the sum fits in eight bits
    always_comb begin
        red_sum   = '0;
        green_sum = '0;
        blue_sum  = '0;
        for (int k = 0; k < rbf_pkg::WIN_TAPS; k++) begin
            red_sum   = red_sum   + 8'(red_term_reg[k]);
            green_sum = green_sum + 8'(green_term_reg[k]);
            blue_sum  = blue_sum  + 8'(blue_term_reg[k]);
        end
    end

endmodule

// ===== hdl/rbf_out_fifo.sv =====
module rbf_out_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  rbf_pkg::rbf_result_t  push_data,
    input  logic                  pop,
    output rbf_pkg::rbf_result_t  head,
    output logic                  not_empty,
    output logic [rbf_pkg::FIFO_AW:0] count
);

    rbf_pkg::rbf_result_t          buf_mem [rbf_pkg::FIFO_DEPTH];
    logic [rbf_pkg::FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [rbf_pkg::FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [rbf_pkg::FIFO_AW:0]     count_reg, count_next;
    logic                          do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = buf_mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

// ===== tb/rgb_box_filter_3x3_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port. It predicts each filtered pixel
// and compares the results in order.
module rgb_box_filter_3x3_checker #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_red_out,
    input  logic [7:0]  m_green_out,
    input  logic [7:0]  m_blue_out,
    input  logic        m_frame_end,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output int          error_count,
    output int          results_pending
);

    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic [11:0] col_pos;
    logic [15:0] row_pos;
    rbf_pkg::rbf_pixel_t  row_above  [MAX_WIDTH];
    rbf_pkg::rbf_pixel_t  row_above2 [MAX_WIDTH];
    rbf_pkg::rbf_window_t window;
    rbf_pkg::rbf_result_t filtered_q [$];

    function automatic int active_width();
        int w;
        w = width_reg;
        if (w < rbf_pkg::MIN_SIDE) w = rbf_pkg::MIN_SIDE;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int active_height();
        int h;
        h = height_reg;
        if (h < rbf_pkg::MIN_SIDE) h = rbf_pkg::MIN_SIDE;
        return h;
    endfunction

    // Sum of the nine rounded ninths of one channel
    function automatic logic [7:0] ninth_sum(input rbf_pkg::rbf_window_t win, input int lsb);
        int total;
        int v;
        total = 0;
        for (int k = 0; k < rbf_pkg::WIN_TAPS; k++) begin
            v = win[k][lsb +: 8];
            total += (v + 4) / 9;
        end
        return total[7:0];
    endfunction

    task automatic take_pixel(input rbf_pkg::rbf_pixel_t pix);
        int w, h, col, row;
        rbf_pkg::rbf_pixel_t up, up2;
        rbf_pkg::rbf_result_t res;
        w = active_width();
        h = active_height();
        col = col_pos;
        row = row_pos;
        if (col >= w) col = 0;
        if (row >= h) row = 0;

        up  = row_above[col];
        up2 = row_above2[col];
        row_above2[col] = up;
        row_above[col]  = pix;

        // shift left, newest column enters on the right
        for (int r = 0; r < rbf_pkg::KERNEL_SIZE; r++) begin
            window[r*3]     = window[r*3 + 1];
            window[r*3 + 1] = window[r*3 + 2];
        end
        window[2] = up2;
        window[5] = up;
        window[8] = pix;

        if (row >= 2 && col >= 2) begin
            res.red       = ninth_sum(window, 16);
            res.green     = ninth_sum(window, 8);
            res.blue      = ninth_sum(window, 0);
            res.frame_end = (row == h - 1) && (col == w - 1);
            filtered_q.push_back(res);
        end

        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        col_pos = col[11:0];
        row_pos = row[15:0];
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        rbf_pkg::rbf_result_t want;
        if (filtered_q.size() == 0) begin
            error_count++;
            $display("%0t: expected no result, got red %0d green %0d blue %0d frame_end %0d",
                     $time, m_red_out, m_green_out, m_blue_out, m_frame_end);
        end else begin
            want = filtered_q.pop_front();
            check_field("red_out", want.red, m_red_out);
            check_field("green_out", want.green, m_green_out);
            check_field("blue_out", want.blue, m_blue_out);
            check_field("frame_end", {7'd0, want.frame_end}, {7'd0, m_frame_end});
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   = rbf_pkg::WIDTH_RESET;
            height_reg  = rbf_pkg::HEIGHT_RESET;
            col_pos     = '0;
            row_pos     = '0;
            window      = '0;
            error_count = 0;
            filtered_q.delete();
        end else begin
            if (m_valid && m_ready) check_result();
            if (cfg_wr_en) begin
                case (cfg_index)
                    rbf_pkg::REG_IMAGE_WIDTH: begin
                        width_reg = cfg_wdata[12:0];
                        col_pos   = '0;
                        row_pos   = '0;
                    end
                    rbf_pkg::REG_IMAGE_HEIGHT: begin
                        height_reg = cfg_wdata;
                        col_pos    = '0;
                        row_pos    = '0;
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready) take_pixel({s_red_in, s_green_in, s_blue_in});
        end
        results_pending = filtered_q.size();
    end

endmodule

// ===== tb/rgb_box_filter_3x3_tb.sv =====
`timescale 1ns / 1ps

module rgb_box_filter_3x3_tb;

    localparam int CLK_PERIOD      = 12;
    localparam int MAX_WIDTH       = 4096;
    localparam int RANDOM_ITEMS    = 960;
    localparam int WIDE_ROW_ITEMS  = 64;
    localparam int SETTLE_CYCLES   = 8;     // margin for the pipeline to drain
    localparam int HOLD_OFF_CYCLES = 80;    // long enough to fill the 8-entry result queue
    localparam int WATCHDOG_LIMIT  = 2000;

    // Indexes with no register behind them
    localparam logic [1:0] REG_UNMAPPED_A = 2'd2;
    localparam logic [1:0] REG_UNMAPPED_B = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_red_in;
    logic [7:0]  s_green_in;
    logic [7:0]  s_blue_in;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_red_out;
    logic [7:0]  m_green_out;
    logic [7:0]  m_blue_out;
    logic        m_frame_end;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    int   error_count;
    int   results_pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   items_sent;
    int   cur_w;
    int   cur_h;
    logic hold_off_req;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    rgb_box_filter_3x3 #(
        .MAX_WIDTH (MAX_WIDTH)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_frame_end (m_frame_end),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    rgb_box_filter_3x3_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_red_in        (s_red_in),
        .s_green_in      (s_green_in),
        .s_blue_in       (s_blue_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_frame_end     (m_frame_end),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    // Receiver: random back-pressure, or a long hold-off on request.
    // The hold-off is counted here so the sender keeps offering items meanwhile.
    always begin
        @(negedge aclk);
        if (hold_off_req) begin
            m_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            hold_off_req = 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Bias towards the extremes and the points where (v + 4) / 9 steps up
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'(9 * $urandom_range(27) + 4);
            3:       return 8'(9 * $urandom_range(27) + 5);
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Offer one pixel, idling first at random; return at the falling edge after acceptance
    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic push_noise_pixels(input int count);
        for (int i = 0; i < count; i++)
            push_pixel(pick_byte(), pick_byte(), pick_byte());
    endtask

    // Hold the write for one cycle; called only while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Stop sending, wait for every predicted result, then let the pipeline go quiet
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (results_pending != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One random phase: maybe reconfigure, then whole frames and perhaps a broken one.
    // Sometimes break off part way for a write to an unmapped index, which must
    // leave the frame position alone.
    task automatic random_frames();
        int w, h, frame_px, count, split;
        logic [15:0] word;
        if ($urandom_range(3) != 0) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
            // upper three bits lie outside the register and must be dropped
            word = 16'(w) | (16'($urandom_range(7)) << 13);
            write_reg(rbf_pkg::REG_IMAGE_WIDTH, word);
            cur_w = (w < rbf_pkg::MIN_SIDE) ? rbf_pkg::MIN_SIDE : w;
        end
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(11))
                0:       h = $urandom_range(2);
                1:       h = 65535;
                default: h = $urandom_range(3, 8);
            endcase
            write_reg(rbf_pkg::REG_IMAGE_HEIGHT, 16'(h));
            cur_h = (h < rbf_pkg::MIN_SIDE) ? rbf_pkg::MIN_SIDE : h;
        end
        // a tall frame never ends here; just feed some rows of it
        frame_px = (cur_h > 64) ? cur_w * $urandom_range(10, 30) : cur_w * cur_h;
        count = frame_px * $urandom_range(1, 3);
        if ($urandom_range(2) == 0) count += $urandom_range(frame_px - 1);
        split = ($urandom_range(4) == 0) ? $urandom_range(1, count - 1) : count;
        push_noise_pixels(split);
        if (split < count) begin
            wait_for_results();
            write_reg($urandom_range(1) ? REG_UNMAPPED_A : REG_UNMAPPED_B, 16'($urandom));
            push_noise_pixels(count - split);
        end
        wait_for_results();
    endtask

    initial begin
        int stage_end;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_red_in      = '0;
        s_green_in    = '0;
        s_blue_in     = '0;
        m_ready       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = rbf_pkg::REG_IMAGE_WIDTH;
        cfg_wdata     = '0;
        hold_off_req  = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 79;
        items_sent    = 0;
        cur_w         = rbf_pkg::MIN_SIDE;
        cur_h         = rbf_pkg::MIN_SIDE;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Smallest frame: red at full scale and green at zero, then a second frame straight after
        // to cover the wrap back to the top-left corner
        write_reg(rbf_pkg::REG_IMAGE_WIDTH, 16'd3);
        write_reg(rbf_pkg::REG_IMAGE_HEIGHT, 16'd3);
        repeat (9) push_pixel(8'd255, 8'd0, 8'd5);
        for (int k = 0; k < 9; k++) begin
            // blue walks the rounding steps of (v + 4) / 9
            push_pixel(8'(k * 31), 8'(255 - k * 31), 8'(9 * k + 4 + (k % 2)));
            if (k == 3) begin
                wait_for_results();
                write_reg(REG_UNMAPPED_B, 16'hFFFF);
            end
        end
        wait_for_results();

        // Undersized geometry clamps to 3 x 3; width bits above the register drop
        write_reg(rbf_pkg::REG_IMAGE_WIDTH, 16'hE002);
        write_reg(rbf_pkg::REG_IMAGE_HEIGHT, 16'd1);
        for (int k = 0; k < 9; k++)
            push_pixel((k % 2) ? 8'd255 : 8'd0, (k % 2) ? 8'd0 : 8'd255, 8'(k * 28));
        wait_for_results();

        // Random frames: sender idles lightly while the receiver idles heavily
        stage_end = items_sent + RANDOM_ITEMS / 3;
        while (items_sent < stage_end) random_frames();

        // Swap the idling
        send_idle_pct = 79;
        recv_idle_pct = 34;
        stage_end = items_sent + RANDOM_ITEMS / 3;
        while (items_sent < stage_end) random_frames();

        // No idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Back-pressure: hold the receiver off until the block stalls its input
        write_reg(rbf_pkg::REG_IMAGE_WIDTH, 16'd4);
        write_reg(rbf_pkg::REG_IMAGE_HEIGHT, 16'd40);
        cur_w = 4;
        cur_h = 40;
        hold_off_req = 1'b1;
        push_noise_pixels(160);
        wait_for_results();

        stage_end = items_sent + RANDOM_ITEMS / 3;
        while (items_sent < stage_end) random_frames();

        // Widest line: an all-ones width clamps to the full line store; feed the
        // start of its first row, which must give no result
        write_reg(rbf_pkg::REG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(rbf_pkg::REG_IMAGE_HEIGHT, 16'd3);
        push_noise_pixels(WIDE_ROW_ITEMS);
        wait_for_results();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
